/* hw/rtl/cpa_pkg.sv */
// Package for the contiguous partition allocator.
// Holds widths, codes, table entry and command types; no dependencies.
`default_nettype none
package cpa_pkg;
  localparam int MAX_PARTITIONS = 32;
  localparam int ADDR_BITS      = 20;
  localparam int SIZE_BITS      = ADDR_BITS + 1;
  localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);
  localparam logic [ADDR_BITS-1:0] TOP_RESET = ADDR_BITS'(999999);

  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_FREED    = 3'd1;
  localparam logic [2:0] ST_NOFIT    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_MEM_TOP    = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_NEXT  = 2'd2,
    FIT_WORST = 2'd3
  } fit_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_LEFT, S_RIGHT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_INIT, OP_SPLIT, OP_TAKE, OP_MERGE
  } op_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] pbegin;
    logic [ADDR_BITS-1:0] pend;
    logic                 pfree;
  } entry_t;

  typedef struct packed {
    op_t                  op;
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] pbegin;
    logic [ADDR_BITS-1:0] pend;
    logic [1:0]           ndrop;
  } tbl_cmd_t;
endpackage
`default_nettype wire

/* hw/rtl/cpa_fit.sv */
// Shared length and fit compare unit, used once per scanned entry.
// Depends on cpa_pkg.
`default_nettype none
module cpa_fit import cpa_pkg::*; (
  input  entry_t                ent,
  input  logic [SIZE_BITS-1:0]  size,
  input  fit_t                  policy,
  input  logic                  have_best,
  input  logic [SIZE_BITS-1:0]  best,
  output logic [SIZE_BITS-1:0]  len,
  output logic [SIZE_BITS-1:0]  diff,
  output logic                  cand,
  output logic                  better
);
  logic [ADDR_BITS-1:0] span_m1;

  always_comb begin
    span_m1 = ent.pend - ent.pbegin;
    len     = {1'b0, span_m1} + SIZE_BITS'(1);
    cand    = ent.pfree && (len >= size);
    diff    = len - size;
    if (!have_best) begin
      better = 1'b1;
    end else if (policy == FIT_BEST) begin
      better = diff <= best;
    end else begin
      better = diff >= best;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/cpa_table.sv */
// Partition table: ordered entries with one read port and whole-row shifts
// for split and merge. Depends on cpa_pkg.
`default_nettype none
module cpa_table import cpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbl_cmd_t             cmd,
  input  logic [ADDR_BITS-1:0] init_top,
  input  logic [IDX_BITS-1:0]  rd_idx,
  output entry_t               rd_ent,
  output logic [CNT_BITS-1:0]  count
);
  entry_t              ent_r [MAX_PARTITIONS];
  entry_t              ent_nxt [MAX_PARTITIONS];
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] idx_w;

  assign idx_w  = {1'b0, cmd.idx};
  assign rd_ent = ent_r[rd_idx];
  assign count  = count_r;

  for (genvar j = 0; j < MAX_PARTITIONS; j++) begin : g_ent
    localparam logic [CNT_BITS-1:0] J = CNT_BITS'(j);
    always_comb begin
      ent_nxt[j] = ent_r[j];
      case (cmd.op)
        OP_INIT: begin
          if (j == 0) ent_nxt[j] = '{pbegin: '0, pend: init_top, pfree: 1'b1};
        end
        OP_SPLIT: begin
          if (J == idx_w) begin
            ent_nxt[j].pend  = cmd.pend;
            ent_nxt[j].pfree = 1'b0;
          end
          if (j > 0) begin
            if (J == idx_w + CNT_BITS'(1)) begin
              ent_nxt[j] = '{pbegin: cmd.pbegin, pend: ent_r[(j > 0) ? j - 1 : 0].pend,
                             pfree: 1'b1};
            end else if (J > idx_w + CNT_BITS'(1)) begin
              ent_nxt[j] = ent_r[(j > 0) ? j - 1 : 0];
            end
          end
        end
        OP_TAKE: begin
          if (J == idx_w) ent_nxt[j].pfree = 1'b0;
        end
        OP_MERGE: begin
          if (J == idx_w) begin
            ent_nxt[j] = '{pbegin: cmd.pbegin, pend: cmd.pend, pfree: 1'b1};
          end else if (J > idx_w) begin
            // pull the rows above down over the merged neighbors
            if (cmd.ndrop == 2'd1 && j + 1 < MAX_PARTITIONS) begin
              ent_nxt[j] = ent_r[(j + 1 < MAX_PARTITIONS) ? j + 1 : j];
            end else if (cmd.ndrop == 2'd2 && j + 2 < MAX_PARTITIONS) begin
              ent_nxt[j] = ent_r[(j + 2 < MAX_PARTITIONS) ? j + 2 : j];
            end
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        if (j == 0) ent_r[j] <= '{pbegin: '0, pend: TOP_RESET, pfree: 1'b1};
        else        ent_r[j].pfree <= 1'b0;
      end else begin
        ent_r[j] <= ent_nxt[j];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      OP_INIT:  count_nxt = CNT_BITS'(1);
      OP_SPLIT: count_nxt = count_r + CNT_BITS'(1);
      OP_MERGE: count_nxt = count_r - CNT_BITS'(cmd.ndrop);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= CNT_BITS'(1);
    else        count_r <= count_nxt;
  end
endmodule
`default_nettype wire

/* hw/rtl/contiguous_partition_allocator_unit.sv */
// Contiguous partition allocator, top level: request sequencer over the table.
// An allocate runs scan (up to the table count of entries), decide and result;
// a free adds left and right neighbor reads, and zero size goes straight to result.
// One item at a time: the single table read port and fit compare unit set the rate.
// Synchronous active-low reset: one free partition 0..999999, fit policy first fit.
`default_nettype none
module contiguous_partition_allocator_unit import cpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ADDR_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [SIZE_BITS-1:0] in_request_size,
  input  logic [ADDR_BITS-1:0] in_free_begin,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [ADDR_BITS-1:0] out_begin_address,
  output logic [ADDR_BITS-1:0] out_end_address,
  output logic [CNT_BITS-1:0]  out_allocated_count
);
  state_t               state_r, state_nxt;
  fit_t                 policy_r;
  logic [IDX_BITS-1:0]  nfp_r, nfp_nxt;
  logic [CNT_BITS-1:0]  total_r, total_nxt;
  logic                 mode_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [IDX_BITS-1:0]  idx_r, idx_nxt;
  logic [CNT_BITS-1:0]  k_r, k_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_BITS-1:0]  sel_r, sel_nxt;
  logic [ADDR_BITS-1:0] selb_r, selb_nxt, sele_r, sele_nxt;
  logic [SIZE_BITS-1:0] sell_r, sell_nxt, best_r, best_nxt;
  logic                 left_r, left_nxt;
  logic [ADDR_BITS-1:0] mb_r, mb_nxt;
  logic [2:0]           st_r, st_nxt;
  logic [ADDR_BITS-1:0] rb_r, rb_nxt, re_r, re_nxt;

  tbl_cmd_t             cmd;
  logic [IDX_BITS-1:0]  rd_idx;
  entry_t               ent;
  logic [CNT_BITS-1:0]  count;
  logic [SIZE_BITS-1:0] len, diff;
  logic                 cand, better;
  logic                 top_wr;
  logic [CNT_BITS-1:0]  sel_w;
  logic                 right;
  logic [ADDR_BITS-1:0] split_b;

  assign top_wr = cfg_we && (cfg_index == REG_MEM_TOP);
  assign sel_w  = {1'b0, sel_r};

  cpa_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .init_top (cfg_wdata),
    .rd_idx   (rd_idx),
    .rd_ent   (ent),
    .count    (count)
  );

  cpa_fit u_fit (
    .ent       (ent),
    .size      (size_r),
    .policy    (policy_r),
    .have_best (found_r),
    .best      (best_r),
    .len       (len),
    .diff      (diff),
    .cand      (cand),
    .better    (better)
  );

  always_comb begin
    state_nxt = state_r;
    nfp_nxt   = nfp_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    found_nxt = found_r;
    sel_nxt   = sel_r;
    selb_nxt  = selb_r;
    sele_nxt  = sele_r;
    sell_nxt  = sell_r;
    best_nxt  = best_r;
    left_nxt  = left_r;
    mb_nxt    = mb_r;
    st_nxt    = st_r;
    rb_nxt    = rb_r;
    re_nxt    = re_r;
    cmd       = '{op: OP_NOP, idx: sel_r, pbegin: '0, pend: '0, ndrop: 2'd0};
    rd_idx    = idx_r;
    right     = 1'b0;
    split_b   = selb_r + ADDR_BITS'(size_r);
    // hold off items while the table is being re-initialized
    in_ready  = (state_r == S_IDLE) && !top_wr;

    unique case (state_r)
      S_IDLE: begin
        if (top_wr) begin
          cmd.op    = OP_INIT;
          nfp_nxt   = '0;
          total_nxt = '0;
        end else if (in_valid) begin
          found_nxt = 1'b0;
          k_nxt     = '0;
          if (in_mode == MODE_ALLOC && in_request_size == '0) begin
            st_nxt    = ST_ZERO;
            rb_nxt    = '0;
            re_nxt    = '0;
            state_nxt = S_OUT;
          end else begin
            // next fit resumes at the saved position when it is still in the table
            if (in_mode == MODE_ALLOC && policy_r == FIT_NEXT && {1'b0, nfp_r} < count)
              idx_nxt = nfp_r;
            else
              idx_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        k_nxt   = k_r + CNT_BITS'(1);
        idx_nxt = ({1'b0, idx_r} + CNT_BITS'(1) == count) ? '0 : idx_r + IDX_BITS'(1);
        if (mode_r != MODE_ALLOC) begin
          if (!ent.pfree && ent.pbegin == addr_r) begin
            found_nxt = 1'b1;
            sel_nxt   = idx_r;
            selb_nxt  = ent.pbegin;
            sele_nxt  = ent.pend;
            state_nxt = S_DECIDE;
          end
        end else if (cand) begin
          if (policy_r == FIT_FIRST || policy_r == FIT_NEXT) begin
            found_nxt = 1'b1;
            sel_nxt   = idx_r;
            selb_nxt  = ent.pbegin;
            sele_nxt  = ent.pend;
            sell_nxt  = len;
            state_nxt = S_DECIDE;
          end else if (better) begin
            found_nxt = 1'b1;
            sel_nxt   = idx_r;
            selb_nxt  = ent.pbegin;
            sele_nxt  = ent.pend;
            sell_nxt  = len;
            best_nxt  = diff;
          end
        end
        if (k_r + CNT_BITS'(1) == count) state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        rb_nxt = '0;
        re_nxt = '0;
        state_nxt = S_OUT;
        if (mode_r == MODE_ALLOC) begin
          if (!found_r) begin
            st_nxt = ST_NOFIT;
          end else if (size_r < sell_r && count >= CNT_BITS'(MAX_PARTITIONS)) begin
            st_nxt = ST_FULL;
          end else begin
            if (size_r < sell_r) begin
              cmd.op     = OP_SPLIT;
              cmd.pbegin = split_b;
              cmd.pend   = split_b - ADDR_BITS'(1);
              re_nxt     = split_b - ADDR_BITS'(1);
            end else begin
              cmd.op = OP_TAKE;
              re_nxt = sele_r;
            end
            rb_nxt    = selb_r;
            total_nxt = total_r + CNT_BITS'(1);
            if (policy_r == FIT_NEXT)
              nfp_nxt = (sel_w + CNT_BITS'(1) < CNT_BITS'(MAX_PARTITIONS)) ?
                        sel_r + IDX_BITS'(1) : '0;
            st_nxt = ST_ALLOC;
          end
        end else if (!found_r) begin
          st_nxt = ST_NOTFOUND;
        end else begin
          state_nxt = S_LEFT;
        end
      end

      S_LEFT: begin
        rd_idx    = sel_r - IDX_BITS'(1);
        left_nxt  = (sel_r != '0) && ent.pfree;
        mb_nxt    = left_nxt ? ent.pbegin : selb_r;
        state_nxt = S_RIGHT;
      end

      S_RIGHT: begin
        rd_idx     = sel_r + IDX_BITS'(1);
        right      = (sel_w + CNT_BITS'(1) < count) && ent.pfree;
        cmd.op     = OP_MERGE;
        cmd.idx    = left_r ? sel_r - IDX_BITS'(1) : sel_r;
        cmd.pbegin = mb_r;
        cmd.pend   = right ? ent.pend : sele_r;
        cmd.ndrop  = {1'b0, left_r} + {1'b0, right};
        if (total_r != '0) total_nxt = total_r - CNT_BITS'(1);
        rb_nxt    = mb_r;
        re_nxt    = cmd.pend;
        st_nxt    = ST_FREED;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      policy_r <= FIT_FIRST;
      nfp_r    <= '0;
      total_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nfp_r   <= nfp_nxt;
      total_r <= total_nxt;
      found_r <= found_nxt;
      if (cfg_we && cfg_index == REG_FIT_POLICY) policy_r <= fit_t'(cfg_wdata[1:0]);
    end
  end

  // hold the request and scan results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && !top_wr) begin
      mode_r <= in_mode;
      size_r <= in_request_size;
      addr_r <= in_free_begin;
    end
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    sel_r  <= sel_nxt;
    selb_r <= selb_nxt;
    sele_r <= sele_nxt;
    sell_r <= sell_nxt;
    best_r <= best_nxt;
    left_r <= left_nxt;
    mb_r   <= mb_nxt;
    st_r   <= st_nxt;
    rb_r   <= rb_nxt;
    re_r   <= re_nxt;
  end

  assign out_valid           = (state_r == S_OUT);
  assign out_status          = st_r;
  assign out_begin_address   = rb_r;
  assign out_end_address     = re_r;
  assign out_allocated_count = total_r;
endmodule
`default_nettype wire

/* hw/rtl/cpa_checker.sv */
// Port-level checks for the partition allocator, bound to the top level.
// Depends on cpa_pkg and contiguous_partition_allocator_unit.
`default_nettype none
module cpa_checker import cpa_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_status,
  input wire logic [ADDR_BITS-1:0] out_begin_address,
  input wire logic [ADDR_BITS-1:0] out_end_address,
  input wire logic [CNT_BITS-1:0]  out_allocated_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result item dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOFIT || out_status == ST_NOTFOUND ||
                  out_status == ST_FULL || out_status == ST_ZERO)
    |-> out_begin_address == '0 && out_end_address == '0)
    else $error("error result carries an address");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_allocated_count <= CNT_BITS'(MAX_PARTITIONS))
    else $error("allocated count out of range");
endmodule

bind contiguous_partition_allocator_unit cpa_checker u_cpa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_begin_address   (out_begin_address),
  .out_end_address     (out_end_address),
  .out_allocated_count (out_allocated_count)
);
`default_nettype wire

/* test/contiguous_partition_allocator_unit_tb.sv */
// Self-checking testbench for the contiguous partition allocator unit.
// Predicts every result from a behavioral copy of the partition table; needs cpa_pkg.
`timescale 1ns / 1ps
module contiguous_partition_allocator_unit_tb;
  import cpa_pkg::*;

  typedef struct {
    logic                 mode;
    logic [SIZE_BITS-1:0] size;
    logic [ADDR_BITS-1:0] fbegin;
  } req_t;

  typedef struct {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] rbegin;
    logic [ADDR_BITS-1:0] rend;
    logic [CNT_BITS-1:0]  count;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FIT_POLICY;
  logic [ADDR_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_ALLOC;
  logic [SIZE_BITS-1:0] in_request_size = '0;
  logic [ADDR_BITS-1:0] in_free_begin = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [ADDR_BITS-1:0] out_begin_address, out_end_address;
  logic [CNT_BITS-1:0] out_allocated_count;

  contiguous_partition_allocator_unit DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow partition table
  fit_t                 pol;
  logic [ADDR_BITS-1:0] top_addr;
  logic [ADDR_BITS-1:0] tb_begin [MAX_PARTITIONS];
  logic [ADDR_BITS-1:0] tb_end [MAX_PARTITIONS];
  bit                   tb_free [MAX_PARTITIONS];
  int                   n_parts, nf_pos, n_alloc;

  req_t  pending_items[$];
  resp_t expected_results[$];
  int    mismatches = 0;
  int    n_checked = 0;
  longint cycles = 0;

  function automatic void table_clear();
    n_parts = 1;
    nf_pos = 0;
    n_alloc = 0;
    tb_begin[0] = '0;
    tb_end[0] = top_addr;
    tb_free[0] = 1'b1;
  endfunction

  function automatic longint part_len(int i);
    logic [ADDR_BITS-1:0] d;
    d = tb_end[i] - tb_begin[i];
    return longint'(d) + 1;
  endfunction

  function automatic void remove_part(int at);
    for (int i = at; i + 1 < n_parts; i++) begin
      tb_begin[i] = tb_begin[i+1];
      tb_end[i] = tb_end[i+1];
      tb_free[i] = tb_free[i+1];
    end
    n_parts--;
  endfunction

  function automatic resp_t predict_alloc_free(req_t r);
    resp_t o;
    bit found;
    int sel, start, i;
    longint sz, best, len, diff;
    o.status = ST_ALLOC;
    o.rbegin = '0;
    o.rend = '0;
    found = 0;
    sel = 0;
    best = 0;
    if (r.mode == MODE_ALLOC) begin
      sz = longint'(r.size);
      if (sz == 0) begin
        o.status = ST_ZERO;
      end else begin
        if (pol == FIT_NEXT) begin
          start = (nf_pos < n_parts) ? nf_pos : 0;
          for (int k = 0; k < n_parts && !found; k++) begin
            i = start + k;
            if (i >= n_parts) i -= n_parts;
            if (tb_free[i] && part_len(i) >= sz) begin
              found = 1;
              sel = i;
            end
          end
        end else begin
          for (i = 0; i < n_parts; i++) begin
            len = part_len(i);
            if (!tb_free[i] || len < sz) continue;
            diff = len - sz;
            if (pol == FIT_FIRST) begin
              found = 1;
              sel = i;
              break;
            end
            if (!found || (pol == FIT_BEST ? diff <= best : diff >= best)) begin
              found = 1;
              sel = i;
              best = diff;
            end
          end
        end
        if (!found) begin
          o.status = ST_NOFIT;
        end else if (sz < part_len(sel) && n_parts >= MAX_PARTITIONS) begin
          o.status = ST_FULL;
        end else begin
          if (sz < part_len(sel)) begin
            for (i = n_parts; i > sel + 1; i--) begin
              tb_begin[i] = tb_begin[i-1];
              tb_end[i] = tb_end[i-1];
              tb_free[i] = tb_free[i-1];
            end
            n_parts++;
            tb_begin[sel+1] = tb_begin[sel] + ADDR_BITS'(sz);
            tb_end[sel+1] = tb_end[sel];
            tb_free[sel+1] = 1'b1;
            tb_end[sel] = tb_begin[sel] + ADDR_BITS'(sz - 1);
          end
          tb_free[sel] = 1'b0;
          n_alloc++;
          if (pol == FIT_NEXT) nf_pos = (sel + 1 < MAX_PARTITIONS) ? sel + 1 : 0;
          o.rbegin = tb_begin[sel];
          o.rend = tb_end[sel];
        end
      end
    end else begin
      for (i = 0; i < n_parts; i++) begin
        if (!tb_free[i] && tb_begin[i] == r.fbegin) begin
          found = 1;
          sel = i;
          break;
        end
      end
      if (!found) begin
        o.status = ST_NOTFOUND;
      end else begin
        tb_free[sel] = 1'b1;
        while (sel > 0 && tb_free[sel-1]) begin
          tb_end[sel-1] = tb_end[sel];
          remove_part(sel);
          sel--;
        end
        while (sel + 1 < n_parts && tb_free[sel+1]) begin
          tb_end[sel] = tb_end[sel+1];
          remove_part(sel + 1);
        end
        if (n_alloc > 0) n_alloc--;
        o.rbegin = tb_begin[sel];
        o.rend = tb_end[sel];
        o.status = ST_FREED;
      end
    end
    o.count = CNT_BITS'(n_alloc);
    return o;
  endfunction

  // Driver
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_alloc_free('{in_mode, in_request_size,
                                                         in_free_begin}));
        pending_items.pop_front();
        in_gap = $urandom_range(0, 4);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && in_gap == 0) begin
          in_valid <= 1'b1;
          in_mode <= pending_items[0].mode;
          in_request_size <= pending_items[0].size;
          in_free_begin <= pending_items[0].fbegin;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // Monitor
  int out_gap = 0;
  always @(posedge clk) begin
    resp_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status || out_begin_address !== e.rbegin ||
              out_end_address !== e.rend || out_allocated_count !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d %0d..%0d cnt=%0d got st=%0d %0d..%0d cnt=%0d",
                       e.status, e.rbegin, e.rend, e.count, out_status,
                       out_begin_address, out_end_address, out_allocated_count);
          end
        end
        out_gap = $urandom_range(0, 4);
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < 5_000_000) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Wait until idle, then hold for the longest free latency.
  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ADDR_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIT_POLICY) pol = fit_t'(val[1:0]);
    else begin
      top_addr = val;
      table_clear();
    end
  endtask

  // Pick a free target that exists most of the time.
  function automatic logic [ADDR_BITS-1:0] pick_free_addr();
    int i;
    if ($urandom_range(0, 9) < 8) begin
      for (int t = 0; t < 8; t++) begin
        i = $urandom_range(0, n_parts - 1);
        if (!tb_free[i]) return tb_begin[i];
      end
    end
    return ADDR_BITS'($urandom());
  endfunction

  task automatic push_alloc(longint sz);
    pending_items.push_back('{MODE_ALLOC, SIZE_BITS'(sz), ADDR_BITS'($urandom())});
  endtask

  task automatic push_free(logic [ADDR_BITS-1:0] a);
    pending_items.push_back('{MODE_FREE, SIZE_BITS'($urandom()), a});
  endtask

  // Random phase, one item at a time; the shadow table advances as each item is accepted.
  task automatic random_phase(int n, int max_sz);
    for (int k = 0; k < n; k++) begin
      while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
        @(posedge clk);
      case ($urandom_range(0, 19))
        0: push_alloc($urandom_range(0, (1 << SIZE_BITS) - 1));
        1: push_alloc(0);
        2, 3, 4, 5, 6, 7, 8, 9, 10: push_alloc($urandom_range(1, max_sz));
        default: push_free(pick_free_addr());
      endcase
    end
  endtask

  initial begin
    pol = FIT_FIRST;
    top_addr = TOP_RESET;
    table_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset table, extremes, exact fits, errors
    push_alloc(0);
    push_alloc(1 << ADDR_BITS);
    push_alloc(1_000_000);
    push_free(20'd0);
    push_alloc(1);
    push_alloc(999_999);
    push_alloc(5);
    push_free(20'hFFFFF);
    push_free(20'd0);
    push_free(20'd1);
    push_alloc((1 << SIZE_BITS) - 1);
    drain();
    write_reg(REG_MEM_TOP, 20'hFFFFF);
    push_alloc(1 << ADDR_BITS);
    push_free(20'd0);
    for (int i = 0; i < 33; i++) push_alloc(1);
    drain();
    write_reg(REG_MEM_TOP, 20'd0);
    push_alloc(2);
    push_alloc(1);
    push_free(20'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_FIT_POLICY, ADDR_BITS'(ph % 4));
      if (ph % 2 == 0) begin
        write_reg(REG_MEM_TOP, (ph == 4) ? 20'hFFFFF : ADDR_BITS'($urandom_range(50, 4000)));
        random_phase(250, 300);
      end else begin
        random_phase(250, 40);
      end
      drain();
    end
    $display("Checked %0d result items: all four fit policies, table resets,", n_checked);
    $display("full table, zero size, no fit, unknown frees and merges under stalls");
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
